### rtl/mofn_pkg.sv
`timescale 1ns / 1ps

package mofn_pkg;

    // Fixed field widths
    localparam int CHANNEL_W = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int TRUES_W   = 4;

    // Largest count the result field can show
    localparam int TRUES_MAX = (1 << TRUES_W) - 1;

    // Default sizes
    localparam int DEF_NUM_CHANNELS = 8;
    localparam int DEF_MAX_WINDOW   = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_TRUE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [CFG_W-1:0] RST_REQUIRED_TRUE = CFG_W'(3);
    localparam logic [CFG_W-1:0] RST_WINDOW_LEN    = CFG_W'(5);

    typedef struct packed {
        logic [CFG_W-1:0] required_true;
        logic [CFG_W-1:0] window_len;
    } cfg_t;

    // Write control from the evaluator to the channel store
    typedef struct packed {
        logic                 we;
        logic                 clear;
        logic [CHANNEL_W-1:0] ch;
    } upd_ctl_t;

endpackage

### rtl/mofn_cfg.sv
`timescale 1ns / 1ps

module mofn_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mofn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mofn_pkg::CFG_W-1:0]     cfg_data,
    output mofn_pkg::cfg_t                 cfg
);
    import mofn_pkg::*;

    cfg_t cfg_reg;

    // Register writes, decoded by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.required_true <= RST_REQUIRED_TRUE;
            cfg_reg.window_len    <= RST_WINDOW_LEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REQUIRED_TRUE: cfg_reg.required_true <= cfg_data;
                REG_WINDOW_LEN:    cfg_reg.window_len    <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/mofn_chan_store.sv
`timescale 1ns / 1ps

module mofn_chan_store #(
    parameter int NUM_CHANNELS = mofn_pkg::DEF_NUM_CHANNELS,
    parameter int MAX_WINDOW   = mofn_pkg::DEF_MAX_WINDOW
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [mofn_pkg::CHANNEL_W-1:0]     rd_ch,
    output logic [MAX_WINDOW-1:0]              rd_hist,
    output logic [$clog2(MAX_WINDOW+1)-1:0]    rd_fill,
    input  mofn_pkg::upd_ctl_t                 upd,
    input  logic [MAX_WINDOW-1:0]              wr_hist,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]    wr_fill
);
    import mofn_pkg::*;

    localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
    localparam int CH_SPAN  = 1 << CHANNEL_W;
    // Only channels the request field can name need storage
    localparam int DEPTH    = (NUM_CHANNELS < CH_SPAN) ? NUM_CHANNELS : CH_SPAN;

    logic [MAX_WINDOW-1:0] hist_reg [DEPTH];
    logic [FILL_W-1:0]     fill_reg [DEPTH];

    // Read select; an unbacked channel reads as empty
    always_comb
    begin
        rd_hist = '0;
        rd_fill = '0;
        for (int e = 0; e < DEPTH; e++)
        begin
            if (rd_ch == CHANNEL_W'(e))
            begin
                rd_hist = hist_reg[e];
                rd_fill = fill_reg[e];
            end
        end
    end

    // Per-channel update or clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < DEPTH; e++)
            begin
                hist_reg[e] <= '0;
                fill_reg[e] <= '0;
            end
        end
        else
        begin
            for (int e = 0; e < DEPTH; e++)
            begin
                if (upd.we && upd.ch == CHANNEL_W'(e))
                begin
                    hist_reg[e] <= upd.clear ? '0 : wr_hist;
                    fill_reg[e] <= upd.clear ? '0 : wr_fill;
                end
            end
        end
    end

    // A kept entry always holds between one and MAX_WINDOW outcomes
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        upd.we && !upd.clear |-> wr_fill != '0 && int'(wr_fill) <= MAX_WINDOW)
        else $error("kept fill count out of range");

endmodule

### rtl/mofn_eval.sv
`timescale 1ns / 1ps

module mofn_eval #(
    parameter int NUM_CHANNELS = mofn_pkg::DEF_NUM_CHANNELS,
    parameter int MAX_WINDOW   = mofn_pkg::DEF_MAX_WINDOW
) (
    input  mofn_pkg::cfg_t                     cfg,
    input  logic                               go,
    input  logic [mofn_pkg::CHANNEL_W-1:0]     ch,
    input  logic                               hit,
    input  logic [MAX_WINDOW-1:0]              rd_hist,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]    rd_fill,
    output logic                               detected,
    output logic [mofn_pkg::TRUES_W-1:0]       trues_out,
    output logic                               bad_config,
    output mofn_pkg::upd_ctl_t                 upd,
    output logic [MAX_WINDOW-1:0]              wr_hist,
    output logic [$clog2(MAX_WINDOW+1)-1:0]    wr_fill
);
    import mofn_pkg::*;

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);

    logic              bad;
    logic              in_range;
    logic [FILL_W-1:0] win;
    logic [FILL_W-1:0] trues;
    logic              hit_det;

    // Config check and window clamp to 1..MAX_WINDOW
    always_comb
    begin
        bad      = cfg.required_true > cfg.window_len;
        in_range = int'(ch) < NUM_CHANNELS;
        if (cfg.window_len == '0)
            win = FILL_W'(1);
        else if (int'(cfg.window_len) > MAX_WINDOW)
            win = FILL_W'(MAX_WINDOW);
        else
            win = FILL_W'(cfg.window_len);
    end

    // Shift in the outcome, grow the fill, count trues in the filled part
    always_comb
    begin
        wr_hist = (rd_hist << 1) | MAX_WINDOW'(hit);
        wr_fill = (rd_fill >= win) ? win : rd_fill + FILL_W'(1);
        trues   = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (wr_hist[i] && i < int'(wr_fill))
                trues = trues + FILL_W'(1);
        end
        hit_det = int'(trues) >= int'(cfg.required_true);
    end

    // Result fields and store update
    always_comb
    begin
        detected   = 1'b0;
        trues_out  = '0;
        bad_config = bad;
        if (!bad && in_range)
        begin
            detected  = hit_det;
            trues_out = (int'(trues) > TRUES_MAX) ? TRUES_W'(TRUES_MAX) : TRUES_W'(trues);
        end
        upd.we    = go && !bad && in_range;
        upd.clear = hit_det;
        upd.ch    = ch;
    end

endmodule

### rtl/m_of_n_event_detector.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// cfg       cfg_we                cfg_index, cfg_data
// request   req_valid, req_stall  channel, hit
// result    res_valid, res_stall  detected, trues_in_window, bad_config
//
// One request per cycle while results are not stalled; each enters the input register,
// then the result register. Channel history is read, updated and written back between
// those two registers, so consecutive requests to one channel need no bypass.
// Reset clears all channel history, fill counts and the request pipeline.
// A stalled result holds the result register; the input register keeps
// taking requests until it too is full, then req_stall is raised.
module m_of_n_event_detector #(
    parameter int NUM_CHANNELS = mofn_pkg::DEF_NUM_CHANNELS,
    parameter int MAX_WINDOW   = mofn_pkg::DEF_MAX_WINDOW
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mofn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mofn_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [mofn_pkg::CHANNEL_W-1:0] channel,
    input  logic                           hit,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic                           detected,
    output logic [mofn_pkg::TRUES_W-1:0]   trues_in_window,
    output logic                           bad_config
);
    import mofn_pkg::*;

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);

    cfg_t                  cfg;
    upd_ctl_t              upd;
    logic [MAX_WINDOW-1:0] rd_hist;
    logic [MAX_WINDOW-1:0] wr_hist;
    logic [FILL_W-1:0]     rd_fill;
    logic [FILL_W-1:0]     wr_fill;

    logic                  s1_valid_reg;
    logic [CHANNEL_W-1:0]  s1_channel_reg;
    logic                  s1_hit_reg;
    logic                  res_valid_reg;
    logic                  det_reg;
    logic [TRUES_W-1:0]    trues_reg;
    logic                  bad_reg;

    logic                  advance;
    logic                  det_c;
    logic [TRUES_W-1:0]    trues_c;
    logic                  bad_c;

    // Pipeline flow
    assign advance   = !res_valid_reg || !res_stall;
    assign req_stall = s1_valid_reg && !advance;

    mofn_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mofn_chan_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_ch   (s1_channel_reg),
        .rd_hist (rd_hist),
        .rd_fill (rd_fill),
        .upd     (upd),
        .wr_hist (wr_hist),
        .wr_fill (wr_fill)
    );

    mofn_eval #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_eval (
        .cfg        (cfg),
        .go         (s1_valid_reg && advance),
        .ch         (s1_channel_reg),
        .hit        (s1_hit_reg),
        .rd_hist    (rd_hist),
        .rd_fill    (rd_fill),
        .detected   (det_c),
        .trues_out  (trues_c),
        .bad_config (bad_c),
        .upd        (upd),
        .wr_hist    (wr_hist),
        .wr_fill    (wr_fill)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!req_stall)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_channel_reg <= channel;
            s1_hit_reg     <= hit;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            det_reg   <= det_c;
            trues_reg <= trues_c;
            bad_reg   <= bad_c;
        end
    end

    assign res_valid       = res_valid_reg;
    assign detected        = det_reg;
    assign trues_in_window = trues_reg;
    assign bad_config      = bad_reg;

    // A full input stage moves on whenever the result register is empty
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !res_valid_reg |=> res_valid_reg)
        else $error("input stage did not advance into empty result register");

    // A config error result carries no detection and no count
    a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && bad_config |-> !detected && trues_in_window == '0)
        else $error("config error result not quiet");

    // A detection means the count reached the required number
    a_det_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && detected |-> trues_in_window >= cfg.required_true)
        else $error("detection below required count");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mofn_pkg::*;

    localparam int CHANNELS    = DEF_NUM_CHANNELS;
    localparam int WINDOW_CAP  = DEF_MAX_WINDOW;
    localparam int QUIET_LIMIT = 2000;
    localparam int PRINT_CAP   = 40;

    // One request: channel and test outcome
    typedef struct packed {
        logic [CHANNEL_W-1:0] ch;
        logic                 h;
    } probe_t;

    // One result as the detector should report it
    typedef struct packed {
        logic               detected;
        logic [TRUES_W-1:0] trues;
        logic               bad;
    } verdict_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [CHANNEL_W-1:0] channel = '0;
    logic                 hit = 1'b0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic                 detected;
    logic [TRUES_W-1:0]   trues_in_window;
    logic                 bad_config;

    // Detector mirror: register copies and per-channel history
    logic [CFG_W-1:0]      need_true = RST_REQUIRED_TRUE;
    logic [CFG_W-1:0]      win_len = RST_WINDOW_LEN;
    logic [WINDOW_CAP-1:0] history [CHANNELS];
    int                    filled [CHANNELS];

    probe_t   backlog [$];
    verdict_t awaited [$];

    int req_idle_pct = 20;
    int res_stall_pct = 20;
    int errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_detects = 0;
    int n_bad_cfg = 0;
    int n_settings = 0;

    m_of_n_event_detector u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .channel         (channel),
        .hit             (hit),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .detected        (detected),
        .trues_in_window (trues_in_window),
        .bad_config      (bad_config)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            history[c] = '0;
            filled[c]  = 0;
        end
    end

    // Shift the outcome in, count trues over the filled span, clear on detection
    function automatic verdict_t score_request(input logic [CHANNEL_W-1:0] ch, input logic h);
        verdict_t              v;
        logic [WINDOW_CAP-1:0] shifted;
        int                    span;
        int                    depth;
        int                    count;
        v = '0;
        if (need_true > win_len)
        begin
            v.bad = 1'b1;
            return v;
        end
        span = int'(win_len);
        if (span < 1)
            span = 1;
        if (span > WINDOW_CAP)
            span = WINDOW_CAP;
        shifted = {history[ch][WINDOW_CAP-2:0], h};
        depth = filled[ch] + 1;
        if (depth > span)
            depth = span;
        count = 0;
        for (int i = 0; i < WINDOW_CAP; i++)
            if (i < depth)
                count += int'(shifted[i]);
        if (count >= int'(need_true))
        begin
            v.detected  = 1'b1;
            history[ch] = '0;
            filled[ch]  = 0;
        end
        else
        begin
            history[ch] = shifted;
            filled[ch]  = depth;
        end
        v.trues = (count > TRUES_MAX) ? TRUES_W'(TRUES_MAX) : TRUES_W'(count);
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     n_results, what, got, want);
    endtask

    // Request driver
    always @(posedge clk)
    begin
        logic   taken;
        probe_t nxt;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            channel   <= '0;
            hit       <= 1'b0;
        end
        else
        begin
            taken = req_valid && !req_stall;
            if (taken)
            begin
                awaited.push_back(score_request(channel, hit));
                n_requests++;
            end
            if (!req_valid || taken)
            begin
                if (backlog.size() != 0 && $urandom_range(99) >= req_idle_pct)
                begin
                    nxt = backlog.pop_front();
                    req_valid <= 1'b1;
                    channel   <= nxt.ch;
                    hit       <= nxt.h;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        verdict_t want;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                n_results++;
                if (awaited.size() == 0)
                    flag_mismatch("result with nothing outstanding", 1, 0);
                else
                begin
                    want = awaited.pop_front();
                    if (detected !== want.detected)
                        flag_mismatch("detected", detected, want.detected);
                    if (trues_in_window !== want.trues)
                        flag_mismatch("trues_in_window", trues_in_window, want.trues);
                    if (bad_config !== want.bad)
                        flag_mismatch("bad_config", bad_config, want.bad);
                    n_detects += int'(want.detected);
                    n_bad_cfg += int'(want.bad);
                end
            end
            res_stall <= ($urandom_range(99) < res_stall_pct);
        end
    end

    // Watchdog: ends the run after a long stretch with no traffic
    initial
    begin
        int quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic queue_request(input int ch, input int h);
        probe_t p;
        p.ch = CHANNEL_W'(ch);
        p.h  = h[0];
        backlog.push_back(p);
    endtask

    // Wait until every request is in and every result is out
    task automatic settle();
        @(negedge clk);
        while (backlog.size() != 0 || req_valid || awaited.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(input int rt, input int wl);
        settle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_REQUIRED_TRUE;
        cfg_data  <= CFG_W'(rt);
        need_true = CFG_W'(rt);
        @(posedge clk);
        cfg_index <= REG_WINDOW_LEN;
        cfg_data  <= CFG_W'(wl);
        win_len = CFG_W'(wl);
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Runs on a focus channel with random outcomes, some traffic on other channels
    task automatic random_burst(input int n, input int hit_pct);
        int focus;
        @(negedge clk);
        focus = $urandom_range(CHANNELS - 1);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(7) == 0)
                focus = $urandom_range(CHANNELS - 1);
            queue_request(($urandom_range(3) == 0) ? $urandom_range(CHANNELS - 1) : focus,
                          ($urandom_range(99) < hit_pct) ? 1 : 0);
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        int rt;
        int wl;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset settings
        @(negedge clk);
        repeat (3) queue_request(0, 1);
        queue_request(0, 1);
        repeat (6) queue_request(7, 0);
        repeat (3) queue_request(7, 1);
        for (int c = 1; c < 7; c++)
            queue_request(c, 1);
        queue_request(5, 0);
        queue_request(5, 1);
        queue_request(5, 0);
        queue_request(5, 1);
        queue_request(3, 0);

        // Edge settings: zero count, zero window, full window, oversize window, bad config
        set_regs(0, 0);
        random_burst(50, 50);
        set_regs(0, 8);
        random_burst(50, 30);
        set_regs(1, 1);
        random_burst(50, 30);
        set_regs(8, 8);
        random_burst(50, 85);
        set_regs(2, 8);
        random_burst(50, 15);
        // shrink the window while channels are partly filled
        set_regs(2, 3);
        random_burst(50, 30);
        set_regs(9, 8);
        random_burst(10, 50);
        set_regs(5, 0);
        random_burst(10, 50);
        set_regs(12, 15);
        random_burst(50, 80);
        set_regs(8, 15);
        random_burst(50, 85);
        set_regs(15, 15);
        random_burst(50, 90);
        set_regs(4, 6);
        random_burst(50, 50);

        // Back-to-back traffic with no idle cycles on either side
        set_regs(3, 7);
        req_idle_pct  = 0;
        res_stall_pct = 0;
        random_burst(200, 45);
        settle();
        req_idle_pct  = 20;
        res_stall_pct = 20;

        // Random settings, mostly valid ones
        for (int p = 0; p < 8; p++)
        begin
            if ($urandom_range(5) == 0)
            begin
                rt = $urandom_range(15);
                wl = $urandom_range(15);
            end
            else
            begin
                rt = $urandom_range(WINDOW_CAP);
                wl = $urandom_range((rt > 1) ? rt : 1, WINDOW_CAP);
            end
            set_regs(rt, wl);
            random_burst(65, $urandom_range(15, 85));
        end

        settle();
        repeat (8) @(posedge clk);
        if (awaited.size() != 0)
            flag_mismatch("results never delivered", awaited.size(), 0);
        $display("run covered %0d requests, %0d results over %0d register settings",
                 n_requests, n_results, n_settings);
        $display("%0d detections, %0d bad-config results, %0d mismatches",
                 n_detects, n_bad_cfg, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
